@@ sv/lcpm_pkg.sv @@
// ----------------------------------------------------------------------------
// lcpm_pkg
// Shared types and constants of the leader cluster point merger.
// ----------------------------------------------------------------------------
package lcpm_pkg;

  localparam int unsigned NumClasses = 3;
  localparam logic [15:0] CountLimit = 16'hFFFF;
  localparam logic [15:0] MergeReset = 16'd500;

  // Request codes
  localparam logic ReqObserve = 1'b0;
  localparam logic ReqClear   = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] RegBallMerge = 2'd0;
  localparam logic [1:0] RegGoalMerge = 2'd1;
  localparam logic [1:0] RegMateMerge = 2'd2;

  // One stored estimate: running sums, sample count and the current mean.
  typedef struct packed {
    logic signed [31:0] sum_x;
    logic signed [31:0] sum_y;
    logic [15:0]        count;
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_WRITE,
    ST_OUT
  } state_e;

endpackage

@@ sv/lcpm_cell.sv @@
// ----------------------------------------------------------------------------
// lcpm_cell
// One storage cell of the estimate ring; takes its neighbour's entry on shift.
// ----------------------------------------------------------------------------
module lcpm_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  lcpm_pkg::entry_t entry_i,
  output lcpm_pkg::entry_t entry_o
);
  import lcpm_pkg::*;

  entry_t entry_q;

  // Entry register; contents are undefined until first written.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ sv/lcpm_div.sv @@
// ----------------------------------------------------------------------------
// lcpm_div
// Bit-serial signed divider: 32-bit sum by 16-bit count, truncated to zero.
// ----------------------------------------------------------------------------
module lcpm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] dividend_i,
  input  logic [15:0]        divisor_i,
  output logic               done_o,
  output logic signed [15:0] quot_o
);
  import lcpm_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [15:0] rem_q;
  logic [31:0] num_q;
  logic [15:0] dvs_q;
  logic        neg_q;
  logic [16:0] shifted;
  logic        ge;
  logic [16:0] diff;

  // One restoring step a cycle.
  assign shifted = {rem_q, num_q[31]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[31];
      num_q <= dividend_i[31] ? 32'(-dividend_i) : dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[15:0] : shifted[15:0];
      num_q <= {num_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 16'(-num_q[15:0]) : num_q[15:0];

endmodule

@@ sv/leader_cluster_point_merger_core.sv @@
// A transaction passes through a scan of the estimate ring, then for a merge the serial
// dividers, then for a merge or a new entry a write-back rotation of the ring; a frozen entry
// or a full table goes to the result after the scan, and a clear or an unknown class goes
// straight to the result. One transaction is in flight at a time; the next input is taken no
// earlier than the cycle after the result leaves. Reset empties all tables and restores
// the merge distances to 500 mm.
// ----------------------------------------------------------------------------
// leader_cluster_point_merger_core
// Running-mean leader clustering of ball, goal post and teammate points held
// in a rotating ring of entry cells.
// ----------------------------------------------------------------------------
module leader_cluster_point_merger_core #(
  parameter int unsigned ENTRIES_PER_CLASS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_req_type_i,
  input  logic [1:0]         in_category_i,
  input  logic signed [15:0] in_pos_x_i,
  input  logic signed [15:0] in_pos_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         out_slot_o,
  output logic signed [15:0] out_mean_x_o,
  output logic signed [15:0] out_mean_y_o,
  output logic [15:0]        out_samples_o,
  output logic               out_created_o,
  output logic               out_dropped_o
);
  import lcpm_pkg::*;

  localparam int unsigned Ring = NumClasses * ENTRIES_PER_CLASS;
  localparam int unsigned RW   = $clog2(Ring);
  localparam int unsigned UW   = $clog2(ENTRIES_PER_CLASS + 1);
  localparam int unsigned SW   = $clog2(Ring + 2);
  localparam logic [UW-1:0] Full = UW'(ENTRIES_PER_CLASS);

  state_e state_q, state_d;

  logic [15:0]   merge_q [NumClasses];
  logic [UW-1:0] used_q  [NumClasses];

  logic signed [15:0] px_q, py_q;
  logic [1:0]    cls_q;
  logic [RW-1:0] base_q;
  logic [31:0]   lim_q;
  logic [UW-1:0] used_sel_q;
  logic [RW-1:0] rot_q;
  logic [SW-1:0] scan_cnt_q;
  logic          found_q;
  logic [RW-1:0] tgt_q;
  entry_t        hit_q;
  entry_t        new_q;

  logic               sq_vld_q;
  logic [32:0]        sqx_q, sqy_q;
  logic [RW-1:0]      sidx_q;
  entry_t             srec_q;

  logic [3:0]         res_slot_q;
  logic signed [15:0] res_mx_q, res_my_q;
  logic [15:0]        res_cnt_q;
  logic               res_created_q, res_dropped_q;

  logic    in_accept;
  logic    scan_end;
  logic    shift;
  logic    in_class;
  logic    match;
  logic    div_start;
  logic    div_done_x, div_done_y;
  logic signed [15:0] quot_x, quot_y;
  entry_t  ring_w [Ring];
  entry_t  wb_rec;
  logic signed [16:0] dx, dy;
  logic signed [33:0] dxsq, dysq;
  logic [RW:0]   cls_hi;
  logic [RW+3:0] hit_slot;
  logic [RW+3:0] new_slot;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign scan_end  = (state_q == ST_SCAN) && (scan_cnt_q == SW'(Ring + 1));
  assign shift     = ((state_q == ST_SCAN) && (scan_cnt_q < SW'(Ring))) ||
                     (state_q == ST_WRITE);
  assign div_start = scan_end && found_q && (hit_q.count != CountLimit);

  // Ring of cells; the head re-enters at the tail, replaced on write-back.
  assign wb_rec = ((state_q == ST_WRITE) && (rot_q == tgt_q)) ? new_q : ring_w[0];

  for (genvar i = 0; i < Ring; i++) begin : g_cell
    lcpm_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .entry_i ((i == Ring - 1) ? wb_rec : ring_w[(i + 1) % Ring]),
      .entry_o (ring_w[i])
    );
  end

  // Head distance: squared differences of the head mean from the point.
  assign dx       = 17'(ring_w[0].mean_x) - 17'(px_q);
  assign dy       = 17'(ring_w[0].mean_y) - 17'(py_q);
  assign dxsq     = dx * dx;
  assign dysq     = dy * dy;
  assign cls_hi   = {1'b0, base_q} + (RW+1)'(used_sel_q);
  assign in_class = (rot_q >= base_q) && ({1'b0, rot_q} < cls_hi);
  assign match    = sq_vld_q &&
                    (({1'b0, sqx_q} + {1'b0, sqy_q}) <= {2'b00, lim_q});
  assign hit_slot = {4'b0000, tgt_q} - {4'b0000, base_q};
  assign new_slot = (RW+4)'(used_sel_q);

  // Mean dividers for a merged entry.
  lcpm_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (hit_q.sum_x + 32'(px_q)),
    .divisor_i  (hit_q.count + 16'd1),
    .done_o     (div_done_x),
    .quot_o     (quot_x)
  );

  lcpm_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (hit_q.sum_y + 32'(py_q)),
    .divisor_i  (hit_q.count + 16'd1),
    .done_o     (div_done_y),
    .quot_o     (quot_y)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_req_type_i == ReqClear || in_category_i == 2'd3) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          if (found_q) begin
            state_d = (hit_q.count == CountLimit) ? ST_OUT : ST_DIV;
          end else if (used_sel_q == Full) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_DIV: begin
        if (div_done_x) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (rot_q == RW'(Ring - 1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rot_q      <= '0;
      scan_cnt_q <= '0;
      found_q    <= 1'b0;
      sq_vld_q   <= 1'b0;
      for (int c = 0; c < NumClasses; c++) begin
        merge_q[c] <= MergeReset;
        used_q[c]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegBallMerge: merge_q[0] <= cfg_data_i;
          RegGoalMerge: merge_q[1] <= cfg_data_i;
          RegMateMerge: merge_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (shift) begin
        rot_q <= (rot_q == RW'(Ring - 1)) ? '0 : rot_q + RW'(1);
      end
      sq_vld_q <= shift && (state_q == ST_SCAN) && in_class;
      if (in_accept) begin
        scan_cnt_q <= '0;
        found_q    <= 1'b0;
        if (in_req_type_i == ReqClear) begin
          for (int c = 0; c < NumClasses; c++) begin
            used_q[c] <= '0;
          end
        end
      end else if (state_q == ST_SCAN) begin
        scan_cnt_q <= scan_cnt_q + SW'(1);
        if (match && !found_q) begin
          found_q <= 1'b1;
        end
      end
      if (scan_end && !found_q && used_sel_q != Full) begin
        used_q[cls_q] <= used_sel_q + UW'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      px_q       <= in_pos_x_i;
      py_q       <= in_pos_y_i;
      cls_q      <= in_category_i;
      base_q     <= RW'(in_category_i) * RW'(ENTRIES_PER_CLASS);
      lim_q      <= (in_category_i == 2'd3) ? 32'd0 :
                    32'(merge_q[in_category_i]) * 32'(merge_q[in_category_i]);
      used_sel_q <= (in_category_i == 2'd3) ? '0 : used_q[in_category_i];
      res_slot_q    <= '0;
      res_mx_q      <= '0;
      res_my_q      <= '0;
      res_cnt_q     <= '0;
      res_created_q <= 1'b0;
      res_dropped_q <= 1'b1;
    end
    sqx_q  <= dxsq[32:0];
    sqy_q  <= dysq[32:0];
    sidx_q <= rot_q;
    srec_q <= ring_w[0];
    if (state_q == ST_SCAN && match && !found_q) begin
      tgt_q <= sidx_q;
      hit_q <= srec_q;
    end
    if (scan_end) begin
      if (found_q) begin
        res_slot_q    <= hit_slot[3:0];
        res_mx_q      <= hit_q.mean_x;
        res_my_q      <= hit_q.mean_y;
        res_cnt_q     <= hit_q.count;
        res_dropped_q <= 1'b0;
        new_q.sum_x   <= hit_q.sum_x + 32'(px_q);
        new_q.sum_y   <= hit_q.sum_y + 32'(py_q);
        new_q.count   <= hit_q.count + 16'd1;
      end else if (used_sel_q != Full) begin
        tgt_q         <= base_q + RW'(used_sel_q);
        new_q.sum_x   <= 32'(px_q);
        new_q.sum_y   <= 32'(py_q);
        new_q.count   <= 16'd1;
        new_q.mean_x  <= px_q;
        new_q.mean_y  <= py_q;
        res_slot_q    <= new_slot[3:0];
        res_mx_q      <= px_q;
        res_my_q      <= py_q;
        res_cnt_q     <= 16'd1;
        res_created_q <= 1'b1;
        res_dropped_q <= 1'b0;
      end
    end
    if (state_q == ST_DIV && div_done_x) begin
      new_q.mean_x <= quot_x;
      new_q.mean_y <= quot_y;
      res_mx_q     <= quot_x;
      res_my_q     <= quot_y;
      res_cnt_q    <= new_q.count;
    end
  end

  // Result outputs.
  always_comb begin
    out_valid_o   = (state_q == ST_OUT);
    out_slot_o    = res_slot_q;
    out_mean_x_o  = res_mx_q;
    out_mean_y_o  = res_my_q;
    out_samples_o = res_cnt_q;
    out_created_o = res_created_q;
    out_dropped_o = res_dropped_q;
  end

  // The ring is back in its home position whenever the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (rot_q == '0))
    else $error("ring not aligned while idle");

  // Both dividers finish together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_x == div_done_y)
    else $error("dividers out of step");

  // No class ever holds more entries than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q[0] <= Full) && (used_q[1] <= Full) && (used_q[2] <= Full))
    else $error("entry count beyond table size");

  // A result that is a creation is never also a drop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_created_o && out_dropped_o))
    else $error("created and dropped together");

endmodule

@@ bench/tb_leader_cluster_point_merger_core.sv @@
// ----------------------------------------------------------------------------
// tb_leader_cluster_point_merger_core
// Self-checking bench for the point merger. A queue of point and clear
// transactions feeds a clocked driver, and a clocked monitor compares each
// result with the estimate tables kept by the bench. The run steps through
// several merge distance settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_leader_cluster_point_merger_core;
  import lcpm_pkg::*;

  localparam int Entries = 16;
  localparam int CycleLimit = 4000000;
  localparam int PhaseItems = 240;

  typedef struct packed {
    logic               req;
    logic [1:0]         cat;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } point_t;

  typedef struct packed {
    logic [3:0]         slot;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic [15:0]        samples;
    logic               created;
    logic               dropped;
  } estimate_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = RegBallMerge;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               in_req_type_i = ReqObserve;
  logic [1:0]         in_category_i = '0;
  logic signed [15:0] in_pos_x_i = '0;
  logic signed [15:0] in_pos_y_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [3:0]         out_slot_o;
  logic signed [15:0] out_mean_x_o;
  logic signed [15:0] out_mean_y_o;
  logic [15:0]        out_samples_o;
  logic               out_created_o;
  logic               out_dropped_o;

  leader_cluster_point_merger_core #(.ENTRIES_PER_CLASS(Entries)) u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_req_type_i, .in_category_i,
    .in_pos_x_i, .in_pos_y_i,
    .out_valid_o, .out_stall_i, .out_slot_o, .out_mean_x_o, .out_mean_y_o,
    .out_samples_o, .out_created_o, .out_dropped_o
  );

  // Bench copy of the estimate tables and merge distances.
  logic signed [31:0] track_sum_x [NumClasses*Entries];
  logic signed [31:0] track_sum_y [NumClasses*Entries];
  logic [15:0]        track_count [NumClasses*Entries];
  int                 track_used  [NumClasses];
  logic [15:0]        merge_mm    [NumClasses];

  point_t    point_q [$];
  estimate_t estimate_q [$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        taken = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Append a transaction to the pending input queue.
  function automatic void queue_point(point_t p);
    point_q.insert(point_q.size(), p);
  endfunction

  // Merge a point into the tables and work out the reported estimate.
  function automatic estimate_t merge_point(point_t p);
    estimate_t res;
    longint    mx, my, dx, dy, d2, lim;
    int        e, base;
    res = '0;
    if (p.req == ReqClear) begin
      for (int c = 0; c < NumClasses; c++) track_used[c] = 0;
      res.dropped = 1'b1;
      return res;
    end
    if (p.cat >= NumClasses) begin
      res.dropped = 1'b1;
      return res;
    end
    lim = longint'(merge_mm[p.cat]) * longint'(merge_mm[p.cat]);
    base = p.cat * Entries;
    for (int k = 0; k < track_used[p.cat]; k++) begin
      e = base + k;
      mx = longint'(track_sum_x[e]) / longint'(track_count[e]);
      my = longint'(track_sum_y[e]) / longint'(track_count[e]);
      dx = mx - longint'(p.px);
      dy = my - longint'(p.py);
      d2 = dx * dx + dy * dy;
      if (d2 <= lim) begin
        // A saturated entry absorbs the point without changing.
        if (track_count[e] != CountLimit) begin
          track_sum_x[e] = track_sum_x[e] + p.px;
          track_sum_y[e] = track_sum_y[e] + p.py;
          track_count[e] = track_count[e] + 16'd1;
        end
        res.slot = k[3:0];
        res.mx = 16'(longint'(track_sum_x[e]) / longint'(track_count[e]));
        res.my = 16'(longint'(track_sum_y[e]) / longint'(track_count[e]));
        res.samples = track_count[e];
        return res;
      end
    end
    if (track_used[p.cat] >= Entries) begin
      res.dropped = 1'b1;
      return res;
    end
    e = base + track_used[p.cat];
    track_sum_x[e] = p.px;
    track_sum_y[e] = p.py;
    track_count[e] = 16'd1;
    res.slot = track_used[p.cat][3:0];
    res.mx = p.px;
    res.my = p.py;
    res.samples = 16'd1;
    res.created = 1'b1;
    track_used[p.cat]++;
    return res;
  endfunction

  function automatic point_t make_point(logic req, logic [1:0] cat, int x, int y);
    point_t p;
    p.req = req;
    p.cat = cat;
    p.px = 16'(x);
    p.py = 16'(y);
    return p;
  endfunction

  // Mostly clustered points so that merges happen, with noise and clears.
  function automatic point_t random_point(int cx, int cy, int spread);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return make_point(ReqClear, 2'($urandom), $urandom, $urandom);
    if (r < 8) return make_point(ReqObserve, 2'd3, $urandom, $urandom);
    if (r < 25) return make_point(ReqObserve, 2'($urandom_range(0, 2)), $urandom, $urandom);
    return make_point(ReqObserve, 2'($urandom_range(0, 2)),
                      cx + $signed($urandom_range(0, 2 * spread)) - spread,
                      cy + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Input driver: presents the queue head and holds it until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || taken)) begin
      taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (point_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_req_type_i <= point_q[0].req;
        in_category_i <= point_q[0].cat;
        in_pos_x_i <= point_q[0].px;
        in_pos_y_i <= point_q[0].py;
        in_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        out_gap = pick_gap();
      end
    end
  end

  // Monitor: predicts on each accepted point and checks each result.
  always @(posedge clk_i) begin
    estimate_t got, want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      if (rst_ni && in_valid_i && !in_stall_o) begin
        estimate_q.insert(estimate_q.size(), merge_point(point_q.pop_front()));
        taken = 1'b1;
      end
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = {out_slot_o, out_mean_x_o, out_mean_y_o, out_samples_o,
               out_created_o, out_dropped_o};
        if (estimate_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction %p", got);
        end else begin
          want = estimate_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    merge_mm[idx] = value;
  endtask

  task automatic wait_idle();
    while (point_q.size() > 0 || in_valid_i || estimate_q.size() > 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    int cx, cy, spread;
    for (int c = 0; c < NumClasses; c++) begin
      track_used[c] = 0;
      merge_mm[c] = MergeReset;
    end
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: clear, unknown class, extreme points, fill one table.
    queue_point(make_point(ReqClear, 2'd0, 0, 0));
    queue_point(make_point(ReqObserve, 2'd3, 32767, -32768));
    queue_point(make_point(ReqObserve, 2'd0, -32768, -32768));
    queue_point(make_point(ReqObserve, 2'd0, 32767, 32767));
    queue_point(make_point(ReqObserve, 2'd0, -32668, -32768));
    queue_point(make_point(ReqObserve, 2'd0, 32767, -32768));
    for (int i = 0; i < 17; i++)
      queue_point(make_point(ReqObserve, 2'd1, -32768 + i * 4000, 100));
    queue_point(make_point(ReqObserve, 2'd1, -32700, 0));
    queue_point(make_point(ReqClear, 2'd3, -1, -1));
    queue_point(make_point(ReqObserve, 2'd2, -1, 0));

    // Each phase uses one merge distance setting.
    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        wait_idle();
        case (phase)
          1: begin
            write_reg(RegBallMerge, 16'd0);
            write_reg(RegGoalMerge, 16'd0);
            write_reg(RegMateMerge, 16'd0);
          end
          2: begin
            write_reg(RegBallMerge, 16'hFFFF);
            write_reg(RegGoalMerge, 16'hFFFF);
            write_reg(RegMateMerge, 16'hFFFF);
          end
          3: begin
            write_reg(RegBallMerge, 16'd1);
            write_reg(RegGoalMerge, 16'd2000);
            write_reg(RegMateMerge, 16'd300);
          end
          default: begin
            write_reg(RegBallMerge, 16'($urandom_range(0, 4000)));
            write_reg(RegGoalMerge, 16'($urandom));
            write_reg(RegMateMerge, 16'($urandom_range(0, 800)));
          end
        endcase
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 40 == 0) begin
          cx = $signed($urandom_range(0, 60000)) - 30000;
          cy = $signed($urandom_range(0, 60000)) - 30000;
          spread = $urandom_range(1, 1500);
        end
        queue_point(random_point(cx, cy, spread));
      end
    end

    wait_idle();
    repeat (200) @(negedge clk_i);
    if (mismatches == 0 && estimate_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
